@@ rtl/tpp_pkg.sv @@
// tpp_pkg: constants, data types and the field weight function of the
// time packet parser. No dependencies; all but tpp_in_reg refer to it.
package tpp_pkg;

	localparam int TOTAL_W = 43;

	localparam logic [7:0] HEADER_BYTE = 8'h55;
	localparam logic [7:0] TYPE_BYTE   = 8'h50;
	localparam logic [7:0] START_SUM   = 8'(HEADER_BYTE + TYPE_BYTE);

	localparam logic [3:0] IDLE_POS  = 4'd1;
	localparam logic [3:0] FIRST_POS = 4'd2;
	localparam logic [3:0] LAST_POS  = 4'd10;

	// data byte slots in packet order
	localparam logic [2:0] FLD_YEAR   = 3'd0;
	localparam logic [2:0] FLD_MONTH  = 3'd1;
	localparam logic [2:0] FLD_DAY    = 3'd2;
	localparam logic [2:0] FLD_HOUR   = 3'd3;
	localparam logic [2:0] FLD_MINUTE = 3'd4;
	localparam logic [2:0] FLD_SECOND = 3'd5;
	localparam logic [2:0] FLD_MS_LO  = 3'd6;
	localparam logic [2:0] FLD_MS_HI  = 3'd7;

	localparam logic [TOTAL_W-1:0] MS_PER_YEAR   = 43'd31540000000;
	localparam logic [TOTAL_W-1:0] MS_PER_MONTH  = 43'd2628000000;
	localparam logic [TOTAL_W-1:0] MS_PER_DAY    = 43'd86400000;
	localparam logic [TOTAL_W-1:0] MS_PER_HOUR   = 43'd3600000;
	localparam logic [TOTAL_W-1:0] MS_PER_MINUTE = 43'd60000;
	localparam logic [TOTAL_W-1:0] MS_PER_SECOND = 43'd1000;
	localparam logic [TOTAL_W-1:0] W_MS_LO       = 43'd1;
	localparam logic [TOTAL_W-1:0] W_MS_HI       = 43'd256;

	typedef struct packed {
		logic [7:0]         year;
		logic [7:0]         month;
		logic [7:0]         day;
		logic [7:0]         hour;
		logic [7:0]         minute;
		logic [7:0]         second;
		logic [15:0]        millis;
		logic [TOTAL_W-1:0] total_ms;
	} result_t;

	// millisecond weight of each data byte slot
	function automatic logic [TOTAL_W-1:0] slot_weight(input logic [2:0] slot);
		logic [TOTAL_W-1:0] w;
		case (slot)
			FLD_YEAR:   w = MS_PER_YEAR;
			FLD_MONTH:  w = MS_PER_MONTH;
			FLD_DAY:    w = MS_PER_DAY;
			FLD_HOUR:   w = MS_PER_HOUR;
			FLD_MINUTE: w = MS_PER_MINUTE;
			FLD_SECOND: w = MS_PER_SECOND;
			FLD_MS_LO:  w = W_MS_LO;
			FLD_MS_HI:  w = W_MS_HI;
			default:    w = '0;
		endcase
		return w;
	endfunction

endpackage

@@ rtl/tpp_in_reg.sv @@
// tpp_in_reg: input register stage holding one received byte word.
// Depends on no other file.
module tpp_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       consume,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	logic load;

	assign in_stall = valid_s1 && !consume;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

@@ rtl/tpp_parser.sv @@
// tpp_parser: packet framing, running checksum, data byte store and the
// running millisecond total. Depends on tpp_pkg.
module tpp_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s1,
	input  logic [7:0]      byte_s1,
	input  logic            res_block,
	output logic            consume,
	output logic            res_valid,
	output tpp_pkg::result_t res
);

	logic                        collecting_q;
	logic [3:0]                  pos_q;
	logic [7:0]                  sum_q;
	logic [7:0]                  fields_q [8];
	logic [tpp_pkg::TOTAL_W-1:0] total_q;

	logic                        at_check;
	logic                        hit;
	logic [3:0]                  pos_eff;
	logic [2:0]                  slot;
	logic [tpp_pkg::TOTAL_W-1:0] addend;

	assign at_check = collecting_q && (pos_q >= tpp_pkg::LAST_POS);
	assign hit      = at_check && (byte_s1 == sum_q);
	// hold the byte only when it would finish a packet the result side cannot take
	assign consume   = valid_s1 && !(hit && res_block);
	assign res_valid = consume && hit;

	// a position below the first data slot reads as the first data slot
	assign pos_eff = (pos_q < tpp_pkg::FIRST_POS) ? tpp_pkg::FIRST_POS : pos_q;
	assign slot    = 3'(pos_eff - tpp_pkg::FIRST_POS);
	assign addend  = tpp_pkg::TOTAL_W'(byte_s1) * tpp_pkg::slot_weight(slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			pos_q        <= tpp_pkg::IDLE_POS;
			sum_q        <= '0;
			total_q      <= '0;
		end else if (consume) begin
			if (!collecting_q) begin
				if (byte_s1 == tpp_pkg::TYPE_BYTE) begin
					collecting_q <= 1'b1;
					pos_q        <= tpp_pkg::FIRST_POS;
					sum_q        <= tpp_pkg::START_SUM;
					total_q      <= '0;
				end
			end else if (at_check) begin
				collecting_q <= 1'b0;
				pos_q        <= tpp_pkg::IDLE_POS;
			end else begin
				sum_q   <= sum_q + byte_s1;
				pos_q   <= pos_eff + 4'd1;
				total_q <= total_q + addend;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (consume && collecting_q && !at_check) begin
			fields_q[slot] <= byte_s1;
		end
	end

	always_comb begin
		res.year     = fields_q[tpp_pkg::FLD_YEAR];
		res.month    = fields_q[tpp_pkg::FLD_MONTH];
		res.day      = fields_q[tpp_pkg::FLD_DAY];
		res.hour     = fields_q[tpp_pkg::FLD_HOUR];
		res.minute   = fields_q[tpp_pkg::FLD_MINUTE];
		res.second   = fields_q[tpp_pkg::FLD_SECOND];
		res.millis   = {fields_q[tpp_pkg::FLD_MS_HI], fields_q[tpp_pkg::FLD_MS_LO]};
		res.total_ms = total_q;
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		collecting_q |-> (pos_q >= tpp_pkg::FIRST_POS && pos_q <= tpp_pkg::LAST_POS))
		else $error("packet position out of range while collecting");

	a_idle_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!collecting_q |-> (pos_q == tpp_pkg::IDLE_POS))
		else $error("idle parser not at idle position");

	a_start_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && !collecting_q && byte_s1 == tpp_pkg::TYPE_BYTE)
		|=> (collecting_q && sum_q == tpp_pkg::START_SUM && total_q == '0))
		else $error("packet start did not seed checksum and total");

	a_no_hold_outside_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !consume) |-> (hit && res_block))
		else $error("byte held without a blocked result");

endmodule

@@ rtl/tpp_out_reg.sv @@
// tpp_out_reg: result register between the parser and the output channel.
// Depends on tpp_pkg for the result type.
module tpp_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  tpp_pkg::result_t res,
	input  logic             out_stall,
	output logic             out_valid,
	output logic             res_block,
	output tpp_pkg::result_t res_q
);

	assign res_block = out_valid && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !res_block)
		else $error("result loaded over a stalled result");

endmodule

@@ rtl/time_packet_parser_to_ms.sv @@
// time_packet_parser_to_ms: top level of the time packet parser.
// Depends on tpp_pkg, tpp_in_reg, tpp_parser and tpp_out_reg.
//
//   channel   direction  handshake             payload
//   input     in         in_valid / in_stall   rx_byte (one byte word)
//   output    out        out_valid / out_stall year, month, day, hour, minute,
//                                              second, millis, total_ms
//
// One byte word is taken every cycle while in_stall is low. The result of a
// good checksum word sits in the input register until the result register can
// take it, then loads the result register, where it is presented.
// The millisecond total is built as the packet arrives: each data byte adds
// one constant-weight product to a 43-bit accumulator, so only one multiply
// and one add sit between registers.
// Reset (arst_n low, asynchronous) returns to idle with position one and a
// zero checksum; the data byte store is not cleared.
// A stalled output holds its result; the input keeps flowing unless the word
// in hand would complete a good packet while the result register is stalled.
module time_packet_parser_to_ms (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  year,
	output logic [7:0]  month,
	output logic [7:0]  day,
	output logic [7:0]  hour,
	output logic [7:0]  minute,
	output logic [7:0]  second,
	output logic [15:0] millis,
	output logic [42:0] total_ms
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             consume;
	logic             res_valid;
	logic             res_block;
	tpp_pkg::result_t res;
	tpp_pkg::result_t res_q;

	tpp_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.consume  (consume),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	tpp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1),
		.res_block (res_block),
		.consume   (consume),
		.res_valid (res_valid),
		.res       (res)
	);

	tpp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res_block (res_block),
		.res_q     (res_q)
	);

	// unpack the result word onto its ports
	assign year     = res_q.year;
	assign month    = res_q.month;
	assign day      = res_q.day;
	assign hour     = res_q.hour;
	assign minute   = res_q.minute;
	assign second   = res_q.second;
	assign millis   = res_q.millis;
	assign total_ms = res_q.total_ms;

endmodule
